// ===== rtl/core/wavhp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the WAV header parser: chunk tags, format constants, status codes, result type.
// No dependencies.
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM         = 16'h0001;
    localparam logic [31:0] FMT_LEN_NO_BITS = 32'd14;
    localparam logic [31:0] FMT_LEN_FULL    = 32'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_NOT_PCM   = 3'd3;
    localparam logic [2:0] ST_EOF       = 3'd4;
    localparam logic [2:0] ST_FMT_SHORT = 3'd5;

    localparam int RES_W   = 244;
    localparam int TDATA_W = 248;

    // first member lands in the top bits, status in the low bits
    typedef struct packed {
        logic        offset_mismatch;
        logic [31:0] data_length;
        logic [31:0] data_offset;
        logic [31:0] riff_length;
        logic [31:0] format_size;
        logic [15:0] sample_bits;
        logic [15:0] frame_bytes;
        logic [31:0] bytes_per_sec;
        logic [31:0] samp_hz;
        logic [15:0] channel_count;
        logic [2:0]  status;
    } res_t;

endpackage

// ===== rtl/core/wavhp_parse.sv =====
`timescale 1ns / 1ps
// Byte-wise RIFF/WAVE parse engine: phase machine, field gathering, held fmt fields.
// Depends on wavhp_pkg.
module wavhp_parse
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] file_length,
    output logic        res_valid,
    output res_t        res
);

    localparam logic [3:0] PH_RIFF    = 4'd0;
    localparam logic [3:0] PH_RSIZE   = 4'd1;
    localparam logic [3:0] PH_FORM    = 4'd2;
    localparam logic [3:0] PH_TAG     = 4'd3;
    localparam logic [3:0] PH_SIZE    = 4'd4;
    localparam logic [3:0] PH_FMTCODE = 4'd5;
    localparam logic [3:0] PH_CHAN    = 4'd6;
    localparam logic [3:0] PH_RATE    = 4'd7;
    localparam logic [3:0] PH_BRATE   = 4'd8;
    localparam logic [3:0] PH_ALIGN   = 4'd9;
    localparam logic [3:0] PH_BITS    = 4'd10;
    localparam logic [3:0] PH_SKIP    = 4'd11;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] skip_reg, skip_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] fmt_len_reg, fmt_len_next;
    logic [31:0] riff_reg, riff_next;
    logic        finished_reg, finished_next;

    logic [31:0] shift_or;
    logic [2:0]  cnt_inc;
    logic [31:0] pos_inc;
    logic [31:0] skip_dec;
    logic        two_byte;
    logic        gathering;
    logic        gdone;

    assign shift_or  = shift_reg | (32'(data_byte) << {cnt_reg[1:0], 3'b000});
    assign cnt_inc   = cnt_reg + 3'd1;
    assign pos_inc   = pos_reg + 32'd1;
    assign skip_dec  = skip_reg - 32'd1;
    assign two_byte  = phase_reg inside {PH_FMTCODE, PH_CHAN, PH_ALIGN, PH_BITS};
    assign gathering = (phase_reg <= PH_BITS);
    assign gdone     = two_byte ? (cnt_inc >= 3'd2) : (cnt_inc >= 3'd4);

    always_comb
    begin
        logic        decided;
        logic [2:0]  dec_status;
        res_t        ok_res;

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        skip_next     = skip_reg;
        fmt_seen_next = fmt_seen_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        brate_next    = brate_reg;
        align_next    = align_reg;
        bits_next     = bits_reg;
        fmt_len_next  = fmt_len_reg;
        riff_next     = riff_reg;
        finished_next = finished_reg;
        res_valid     = 1'b0;
        res           = '0;
        decided       = 1'b0;
        dec_status    = ST_OK;
        ok_res        = '0;

        if (accept && !finished_reg)
        begin
            pos_next = pos_inc;
            if (gathering)
            begin
                if (gdone)
                begin
                    shift_next = '0;
                    cnt_next   = '0;
                end
                else
                begin
                    shift_next = shift_or;
                    cnt_next   = cnt_inc;
                end
            end

            unique case (phase_reg)
                PH_RIFF:
                begin
                    if (gdone)
                    begin
                        if (shift_or != TAG_RIFF)
                        begin
                            decided    = 1'b1;
                            dec_status = ST_NOT_RIFF;
                        end
                        else
                        begin
                            phase_next = PH_RSIZE;
                        end
                    end
                end
                PH_RSIZE:
                begin
                    if (gdone)
                    begin
                        riff_next  = shift_or;
                        phase_next = PH_FORM;
                    end
                end
                PH_FORM:
                begin
                    if (gdone)
                    begin
                        if (shift_or != TAG_WAVE)
                        begin
                            decided    = 1'b1;
                            dec_status = ST_NOT_WAVE;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                end
                PH_TAG:
                begin
                    if (gdone)
                    begin
                        tag_next   = shift_or;
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    if (gdone)
                    begin
                        size_next = shift_or;
                        if (tag_reg == TAG_FMT)
                        begin
                            fmt_len_next = shift_or;
                            if (fmt_seen_reg)
                            begin
                                skip_next  = shift_or;
                                phase_next = (shift_or != '0) ? PH_SKIP : PH_TAG;
                            end
                            else if (shift_or < FMT_LEN_NO_BITS || shift_or == 32'd15)
                            begin
                                decided    = 1'b1;
                                dec_status = ST_FMT_SHORT;
                            end
                            else
                            begin
                                phase_next = PH_FMTCODE;
                            end
                        end
                        else if (tag_reg == TAG_DATA)
                        begin
                            decided                = 1'b1;
                            dec_status             = ST_OK;
                            ok_res.channel_count   = chan_reg;
                            ok_res.samp_hz         = rate_reg;
                            ok_res.bytes_per_sec   = brate_reg;
                            ok_res.frame_bytes     = align_reg;
                            ok_res.sample_bits     = bits_reg;
                            ok_res.format_size     = fmt_len_reg;
                            ok_res.data_offset     = pos_inc;
                            ok_res.offset_mismatch = (riff_reg + 32'd8 - shift_or) != pos_inc;
                            if (shift_or == '0)
                            begin
                                ok_res.data_length = file_length - pos_inc;
                                ok_res.riff_length = file_length - 32'd8;
                            end
                            else
                            begin
                                ok_res.data_length = shift_or;
                                ok_res.riff_length = riff_reg;
                            end
                        end
                        else
                        begin
                            skip_next  = shift_or;
                            phase_next = (shift_or != '0) ? PH_SKIP : PH_TAG;
                        end
                    end
                end
                PH_FMTCODE:
                begin
                    if (gdone)
                    begin
                        if (shift_or[15:0] != FMT_PCM)
                        begin
                            decided    = 1'b1;
                            dec_status = ST_NOT_PCM;
                        end
                        else
                        begin
                            phase_next = PH_CHAN;
                        end
                    end
                end
                PH_CHAN:
                begin
                    if (gdone)
                    begin
                        chan_next  = shift_or[15:0];
                        phase_next = PH_RATE;
                    end
                end
                PH_RATE:
                begin
                    if (gdone)
                    begin
                        rate_next  = shift_or;
                        phase_next = PH_BRATE;
                    end
                end
                PH_BRATE:
                begin
                    if (gdone)
                    begin
                        brate_next = shift_or;
                        phase_next = PH_ALIGN;
                    end
                end
                PH_ALIGN:
                begin
                    if (gdone)
                    begin
                        align_next = shift_or[15:0];
                        if (size_reg == FMT_LEN_NO_BITS)
                        begin
                            bits_next     = 16'd8;
                            fmt_seen_next = 1'b1;
                            skip_next     = '0;
                            phase_next    = PH_TAG;
                        end
                        else
                        begin
                            phase_next = PH_BITS;
                        end
                    end
                end
                PH_BITS:
                begin
                    if (gdone)
                    begin
                        bits_next     = shift_or[15:0];
                        fmt_seen_next = 1'b1;
                        skip_next     = size_reg - FMT_LEN_FULL;
                        phase_next    = (size_reg != FMT_LEN_FULL) ? PH_SKIP : PH_TAG;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase

            if (decided)
            begin
                res_valid     = 1'b1;
                res           = (dec_status == ST_OK) ? ok_res : '0;
                res.status    = dec_status;
                finished_next = 1'b1;
            end
            else if (last_byte)
            begin
                res_valid  = 1'b1;
                res        = '0;
                res.status = ST_EOF;
            end
        end

        // end of file re-arms the parser
        if (accept && last_byte)
        begin
            phase_next    = PH_RIFF;
            pos_next      = '0;
            shift_next    = '0;
            cnt_next      = '0;
            tag_next      = '0;
            size_next     = '0;
            skip_next     = '0;
            fmt_seen_next = 1'b0;
            chan_next     = '0;
            rate_next     = '0;
            brate_next    = '0;
            align_next    = '0;
            bits_next     = '0;
            fmt_len_next  = '0;
            riff_next     = '0;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            pos_reg      <= '0;
            shift_reg    <= '0;
            cnt_reg      <= '0;
            tag_reg      <= '0;
            size_reg     <= '0;
            skip_reg     <= '0;
            fmt_seen_reg <= 1'b0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            brate_reg    <= '0;
            align_reg    <= '0;
            bits_reg     <= '0;
            fmt_len_reg  <= '0;
            riff_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            cnt_reg      <= cnt_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            skip_reg     <= skip_next;
            fmt_seen_reg <= fmt_seen_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            brate_reg    <= brate_next;
            align_reg    <= align_next;
            bits_reg     <= bits_next;
            fmt_len_reg  <= fmt_len_next;
            riff_reg     <= riff_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== rtl/core/wavhp_out.sv =====
`timescale 1ns / 1ps
// Result register for the WAV header parser output stream.
// Depends on wavhp_pkg.
module wavhp_out
    import wavhp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  res_t               res,
    output logic               ready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic valid_reg;
    res_t data_reg;

    assign ready         = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - RES_W){1'b0}}, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ===== rtl/core/wav_header_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the RIFF/WAVE header parser: config register, parse engine, result register.
// Depends on wavhp_pkg, wavhp_parse, wavhp_out.
//
// channel   | dir | payload
// s_axis    | in  | tdata[7:0] data_byte, tlast last_byte
// m_axis    | out | tdata: status, channel_count, samp_hz, bytes_per_sec, frame_bytes,
//           |     |        sample_bits, format_size, riff_length, data_offset,
//           |     |        data_length, offset_mismatch (low bits up, zero pad to 248)
// cfg       | in  | cfg_wr_en / cfg_wr_data = file_length
//
// One byte per cycle while s_axis_tready is high; the result of a deciding beat is loaded into
// the output register at the edge that accepts that beat and is offered from the next cycle on.
// s_axis_tready drops only while a result sits in the output register and m_axis_tready is low.
// rst_n is asynchronous and clears the parser, output valid and file_length.
module wav_header_parser_top
    import wavhp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tlast,   // last_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata    // status .. offset_mismatch, see table
);

    logic [31:0] file_length_reg;
    logic        accept;
    logic        res_valid;
    res_t        res;
    logic        out_ready;

    assign s_axis_tready = out_ready;
    assign accept        = s_axis_tvalid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            file_length_reg <= cfg_wr_data;
        end
    end

    wavhp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .last_byte   (s_axis_tlast),
        .file_length (file_length_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    wavhp_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .ready         (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
